// ===== rtl/core/icdf_pkg.sv =====
`timescale 1ns / 1ps

package icdf_pkg;

    localparam int SIDE         = 64;
    localparam int ROW_W        = 6;
    localparam int CH_W         = 8;
    localparam int V_W          = 7;
    localparam int K_W          = 4;
    localparam int P_W          = V_W + K_W - 1;
    localparam int RECIP_W      = 13;
    localparam int Q_W          = P_W + RECIP_W;
    localparam int RECIP_SH     = 16;
    localparam int CW           = (ROW_W + 1 > $clog2(SIDE + 1)) ? ROW_W + 1
                                                                 : $clog2(SIDE + 1);
    localparam int BORDER_RINGS = 4;
    localparam int GRADIENT_END = 12;
    localparam int RING_OFS     = 3;

    // floor(x * 7282 / 65536) == floor(x / 9) for every x below 2**P_W
    localparam logic [RECIP_W-1:0] RECIP9      = RECIP_W'(7282);
    localparam logic [CH_W-1:0]    ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic            border;
        logic            grad;
        logic            corner;
        logic [K_W-1:0]  k;
        logic [CH_W-1:0] alpha;
    } t_ctl;

    typedef struct packed {
        t_ctl                  ctl;
        logic [2:0][V_W-1:0]   ch;
    } t_pix;

endpackage

// ===== rtl/core/icdf_if.sv =====
`timescale 1ns / 1ps

interface icdf_pix_if;
    logic                                  valid;
    logic                                  ready;
    logic [icdf_pkg::ROW_W-1:0]            row;
    logic [icdf_pkg::ROW_W-1:0]            col;
    logic [icdf_pkg::CH_W-1:0]             red_in;
    logic [icdf_pkg::CH_W-1:0]             green_in;
    logic [icdf_pkg::CH_W-1:0]             blue_in;
    logic [icdf_pkg::CH_W-1:0]             alpha_in;

    modport source (output valid, row, col, red_in, green_in, blue_in, alpha_in,
                    input ready);
    modport sink (input valid, row, col, red_in, green_in, blue_in, alpha_in,
                  output ready);
endinterface

interface icdf_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [icdf_pkg::CH_W-1:0]             red_out;
    logic [icdf_pkg::CH_W-1:0]             green_out;
    logic [icdf_pkg::CH_W-1:0]             blue_out;
    logic [icdf_pkg::CH_W-1:0]             alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out,
                  output ready);
endinterface

// ===== rtl/core/icdf_front.sv =====
`timescale 1ns / 1ps

module icdf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic                        i_en1,
    input  logic                        i_en2,
    input  logic [icdf_pkg::ROW_W-1:0]  i_row,
    input  logic [icdf_pkg::ROW_W-1:0]  i_col,
    input  logic [2:0][icdf_pkg::CH_W-1:0] i_ch,
    input  logic [icdf_pkg::CH_W-1:0]   i_alpha,
    output logic                        o_vld1,
    output logic                        o_vld2,
    output icdf_pkg::t_pix              o_pix
);

    localparam int CW = icdf_pkg::CW;

    logic                               r_vld1;
    logic                               r_vld2;
    icdf_pkg::t_ctl                     r_ctl1;
    logic [2:0][icdf_pkg::CH_W-1:0]     r_ch1;
    logic [icdf_pkg::CH_W-1:0]          r_lo;
    logic [icdf_pkg::CH_W-1:0]          r_hi;
    icdf_pkg::t_pix                     r_pix2;

    logic [CW-1:0]                      row_e;
    logic [CW-1:0]                      col_e;
    logic [CW-1:0]                      rb;
    logic [CW-1:0]                      cb;
    logic [CW-1:0]                      ring;
    logic                               outside;
    icdf_pkg::t_ctl                     n_ctl1;
    logic [icdf_pkg::CH_W-1:0]          n_lo;
    logic [icdf_pkg::CH_W-1:0]          n_hi;
    logic [icdf_pkg::CH_W-1:0]          ave;
    icdf_pkg::t_pix                     n_pix2;

    always_comb begin
        row_e   = CW'(i_row);
        col_e   = CW'(i_col);
        rb      = CW'(icdf_pkg::SIDE - 1) - row_e;
        cb      = CW'(icdf_pkg::SIDE - 1) - col_e;
        outside = (row_e >= CW'(icdf_pkg::SIDE)) || (col_e >= CW'(icdf_pkg::SIDE));
        ring    = row_e;
        if (col_e < ring) begin
            ring = col_e;
        end
        if (rb < ring) begin
            ring = rb;
        end
        if (cb < ring) begin
            ring = cb;
        end
        n_ctl1.border = outside || (ring < CW'(icdf_pkg::BORDER_RINGS));
        n_ctl1.grad   = ring < CW'(icdf_pkg::GRADIENT_END);
        n_ctl1.corner = (row_e == col_e) || ((row_e + col_e) == CW'(icdf_pkg::SIDE - 1));
        n_ctl1.k      = icdf_pkg::K_W'(ring - CW'(icdf_pkg::RING_OFS));
        n_ctl1.alpha  = i_alpha;

        n_lo = i_ch[0];
        n_hi = i_ch[0];
        for (int i = 1; i < 3; i++) begin
            if (i_ch[i] < n_lo) begin
                n_lo = i_ch[i];
            end
            if (i_ch[i] > n_hi) begin
                n_hi = i_ch[i];
            end
        end
    end

    always_comb begin
        ave        = icdf_pkg::CH_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
        n_pix2.ctl = r_ctl1;
        for (int i = 0; i < 3; i++) begin
            n_pix2.ch[i] = icdf_pkg::V_W'(({1'b0, ave} + {1'b0, r_ch1[i]}) >> 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (i_en1) begin
                r_vld1 <= i_vld;
            end
            if (i_en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_ctl1 <= n_ctl1;
            r_ch1  <= i_ch;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
        end
        if (i_en2) begin
            r_pix2 <= n_pix2;
        end
    end

    assign o_vld1 = r_vld1;
    assign o_vld2 = r_vld2;
    assign o_pix  = r_pix2;

endmodule

// ===== rtl/core/icdf_scale.sv =====
`timescale 1ns / 1ps

module icdf_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic            i_en_mul,
    input  logic            i_en_div,
    input  logic            i_apply,
    input  icdf_pkg::t_pix  i_pix,
    output logic            o_vld_mul,
    output logic            o_vld,
    output icdf_pkg::t_pix  o_pix
);

    localparam int P_W = icdf_pkg::P_W;
    localparam int Q_W = icdf_pkg::Q_W;

    logic                   r_vld_mul;
    logic                   r_vld_div;
    logic                   r_apply;
    icdf_pkg::t_pix         r_pix_mul;
    logic [2:0][P_W-1:0]    r_prod;
    icdf_pkg::t_pix         r_pix_div;

    logic [2:0][P_W-1:0]    n_prod;
    logic [2:0][Q_W-1:0]    quot_full;
    icdf_pkg::t_pix         n_pix_div;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = P_W'(P_W'(i_pix.ch[i]) * P_W'(i_pix.ctl.k));
        end
    end

    // divide by 9: reciprocal multiply, exact over the product range
    always_comb begin
        n_pix_div.ctl = r_pix_mul.ctl;
        for (int i = 0; i < 3; i++) begin
            quot_full[i] = Q_W'(r_prod[i]) * Q_W'(icdf_pkg::RECIP9);
            n_pix_div.ch[i] = r_apply ? quot_full[i][icdf_pkg::RECIP_SH +: icdf_pkg::V_W]
                                      : r_pix_mul.ch[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_mul <= 1'b0;
            r_vld_div <= 1'b0;
        end else begin
            if (i_en_mul) begin
                r_vld_mul <= i_vld;
            end
            if (i_en_div) begin
                r_vld_div <= r_vld_mul;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_pix_mul <= i_pix;
            r_prod    <= n_prod;
            r_apply   <= i_apply;
        end
        if (i_en_div) begin
            r_pix_div <= n_pix_div;
        end
    end

    assign o_vld_mul = r_vld_mul;
    assign o_vld     = r_vld_div;
    assign o_pix     = r_pix_div;

endmodule

// ===== rtl/core/icon_darken_frame_filter.sv =====
`timescale 1ns / 1ps

// Disabled-icon frame filter, one pixel per beat.
// Input channel i_pix: row, col and R, G, B, A of one icon pixel.
// Output channel o_res: filtered R, G, B and alpha for that pixel, in order.
// Pixels in the outer four rings come out opaque black; the rest are
// desaturated, darkened and, in rings 4 to 11, faded toward the frame.
// An accepted input beat passes the registered stages in order: ring/min-max,
// average, two multiply-then-divide-by-9 passes, output register.
// One pixel per cycle unless o_res stalls; no state is kept between pixels.
// Every stage has its own valid bit and holds when the stage ahead is full
// and stalled, so bubbles are squeezed out: with o_res.ready low the block
// still takes up to 7 beats before i_pix.ready drops.
// Reset (i_rst_n low, synchronous) empties the pipeline; no beat is
// presented on o_res until new input is accepted.

module icon_darken_frame_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icdf_pix_if.sink    i_pix,
    icdf_res_if.source  o_res
);

    logic                           vld1;
    logic                           vld2;
    logic                           vld3;
    logic                           vld4;
    logic                           vld5;
    logic                           vld6;
    logic                           r_vld7;
    logic                           en1;
    logic                           en2;
    logic                           en3;
    logic                           en4;
    logic                           en5;
    logic                           en6;
    logic                           en7;
    icdf_pkg::t_pix                 pix2;
    icdf_pkg::t_pix                 pix4;
    icdf_pkg::t_pix                 pix6;
    logic [2:0][icdf_pkg::CH_W-1:0] ch_in;
    logic [2:0][icdf_pkg::CH_W-1:0] r_ch_out;
    logic [icdf_pkg::CH_W-1:0]      r_alpha_out;
    logic [2:0][icdf_pkg::CH_W-1:0] n_ch_out;
    logic [icdf_pkg::CH_W-1:0]      n_alpha_out;

    assign en7 = !r_vld7 || o_res.ready;
    assign en6 = !vld6 || en7;
    assign en5 = !vld5 || en6;
    assign en4 = !vld4 || en5;
    assign en3 = !vld3 || en4;
    assign en2 = !vld2 || en3;
    assign en1 = !vld1 || en2;

    assign i_pix.ready = en1;
    assign ch_in = {i_pix.blue_in, i_pix.green_in, i_pix.red_in};

    icdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_pix.valid),
        .i_en1   (en1),
        .i_en2   (en2),
        .i_row   (i_pix.row),
        .i_col   (i_pix.col),
        .i_ch    (ch_in),
        .i_alpha (i_pix.alpha_in),
        .o_vld1  (vld1),
        .o_vld2  (vld2),
        .o_pix   (pix2)
    );

    icdf_scale u_scale_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (vld2),
        .i_en_mul  (en3),
        .i_en_div  (en4),
        .i_apply   (pix2.ctl.grad),
        .i_pix     (pix2),
        .o_vld_mul (vld3),
        .o_vld     (vld4),
        .o_pix     (pix4)
    );

    icdf_scale u_scale_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (vld4),
        .i_en_mul  (en5),
        .i_en_div  (en6),
        .i_apply   (pix4.ctl.grad && pix4.ctl.corner),
        .i_pix     (pix4),
        .o_vld_mul (vld5),
        .o_vld     (vld6),
        .o_pix     (pix6)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ch_out[i] = pix6.ctl.border ? '0 : icdf_pkg::CH_W'(pix6.ch[i]);
        end
        n_alpha_out = pix6.ctl.border ? icdf_pkg::ALPHA_OPAQUE : pix6.ctl.alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld7 <= 1'b0;
        end else if (en7) begin
            r_vld7 <= vld6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r_ch_out    <= n_ch_out;
            r_alpha_out <= n_alpha_out;
        end
    end

    assign o_res.valid     = r_vld7;
    assign o_res.red_out   = r_ch_out[0];
    assign o_res.green_out = r_ch_out[1];
    assign o_res.blue_out  = r_ch_out[2];
    assign o_res.alpha_out = r_alpha_out;

`ifndef ASSERT_OFF
    logic [6:0] occ;
    logic       acc_in;
    logic       acc_out;

    assign occ     = {r_vld7, vld6, vld5, vld4, vld3, vld2, vld1};
    assign acc_in  = i_pix.valid && i_pix.ready;
    assign acc_out = o_res.valid && o_res.ready;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (occ == '0) |-> i_pix.ready)
        else $error("input stalled with empty pipeline");

    a_occ_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(acc_in && !acc_out))
            |-> ($countones(occ) == $countones($past(occ)) + 1))
        else $error("accepted beat not held in pipeline");

    a_occ_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(!acc_in && acc_out))
            |-> ($countones(occ) + 1 == $countones($past(occ))))
        else $error("pipeline occupancy lost or repeated a beat");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_TICKS = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 50;

    localparam int ROW_W        = icdf_pkg::ROW_W;
    localparam int CH_W         = icdf_pkg::CH_W;
    localparam int SIDE         = icdf_pkg::SIDE;
    localparam int BORDER_RINGS = icdf_pkg::BORDER_RINGS;
    localparam int GRADIENT_END = icdf_pkg::GRADIENT_END;
    localparam int RING_OFS     = icdf_pkg::RING_OFS;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = icdf_pkg::ALPHA_OPAQUE;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_rgba;

    logic i_clk;
    logic i_rst_n;

    icdf_pix_if pix ();
    icdf_res_if res ();

    icon_darken_frame_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res)
    );

    t_pixel pixels_to_send[$];
    t_rgba  darkened_due[$];

    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  stall_request;
    bit  output_held;
    int  mismatches;
    int  pixels_sent;
    int  results_checked;
    int  frame_pixels;
    int  faded_pixels;
    int  cycle_count;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Expected output for one pixel; also hands back the ring it sits on.
    function automatic t_rgba darken_pixel(input t_pixel p, output int ring);
        int    ch[3];
        int    lo;
        int    hi;
        int    ave;
        int    v;
        bit    corner;
        t_rgba out;
        ring = p.row;
        if (p.col < ring) ring = p.col;
        if (SIDE - 1 - p.row < ring) ring = SIDE - 1 - p.row;
        if (SIDE - 1 - p.col < ring) ring = SIDE - 1 - p.col;
        if (p.row >= SIDE || p.col >= SIDE) ring = 0;
        if (ring < BORDER_RINGS) begin
            out = '{red: '0, green: '0, blue: '0, alpha: ALPHA_OPAQUE};
            return out;
        end
        ch[0] = p.red;
        ch[1] = p.green;
        ch[2] = p.blue;
        lo = ch[0];
        hi = ch[0];
        for (int i = 1; i < 3; i++) begin
            if (ch[i] < lo) lo = ch[i];
            if (ch[i] > hi) hi = ch[i];
        end
        ave = (lo + hi) / 2;
        corner = (p.row == p.col) || (int'(p.row) + int'(p.col) == SIDE - 1);
        for (int i = 0; i < 3; i++) begin
            v = (ave + ch[i]) / 4;
            if (ring < GRADIENT_END) begin
                v = v * (ring - RING_OFS) / 9;
                if (corner) v = v * (ring - RING_OFS) / 9;
            end
            ch[i] = v;
        end
        out.red   = CH_W'(ch[0]);
        out.green = CH_W'(ch[1]);
        out.blue  = CH_W'(ch[2]);
        out.alpha = p.alpha;
        return out;
    endfunction

    function automatic logic [CH_W-1:0] random_channel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    // Bias toward the fade band and its diagonals, where the arithmetic lives.
    function automatic t_pixel random_pixel();
        t_pixel p;
        int     r;
        int     far;
        p.row = ROW_W'($urandom);
        p.col = ROW_W'($urandom);
        r = $urandom_range(GRADIENT_END - 1, BORDER_RINGS);
        far = SIDE - 1 - r;
        case ($urandom_range(9))
            3, 4, 5, 6: begin
                case ($urandom_range(3))
                    0: begin
                        p.row = ROW_W'(r);
                        p.col = ROW_W'($urandom_range(far, r));
                    end
                    1: begin
                        p.row = ROW_W'(far);
                        p.col = ROW_W'($urandom_range(far, r));
                    end
                    2: begin
                        p.col = ROW_W'(r);
                        p.row = ROW_W'($urandom_range(far, r));
                    end
                    default: begin
                        p.col = ROW_W'(far);
                        p.row = ROW_W'($urandom_range(far, r));
                    end
                endcase
            end
            7, 8: begin
                p.row = ROW_W'($urandom_range(1) ? r : far);
                p.col = ROW_W'($urandom_range(1) ? r : far);
            end
            9: begin
                p.row = ROW_W'($urandom_range(SIDE - 1 - GRADIENT_END, GRADIENT_END));
                p.col = $urandom_range(1) ? p.row
                                          : ROW_W'($urandom_range(SIDE - 1 - GRADIENT_END,
                                                                  GRADIENT_END));
            end
            default: ;
        endcase
        p.red   = random_channel();
        p.green = random_channel();
        p.blue  = random_channel();
        p.alpha = random_channel();
        return p;
    endfunction

    task automatic add_pixel(input int row, input int col, input int r, input int g,
                             input int b, input int a);
        pixels_to_send = {pixels_to_send,
                          t_pixel'{row: ROW_W'(row), col: ROW_W'(col), red: CH_W'(r),
                                   green: CH_W'(g), blue: CH_W'(b), alpha: CH_W'(a)}};
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at result %0d: %s = %0d, expected %0d",
                     results_checked, field, got, want);
        mismatches++;
    endtask

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pixels_to_send.size() != 0 || pix.valid || darkened_due.size() != 0);
    endtask

    always @(posedge i_clk) begin : drive_pixels
        t_pixel next_pix;
        int     ring;
        t_rgba  want;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) begin
                want = darken_pixel(t_pixel'{row: pix.row, col: pix.col, red: pix.red_in,
                                             green: pix.green_in, blue: pix.blue_in,
                                             alpha: pix.alpha_in}, ring);
                darkened_due = {darkened_due, want};
                pixels_sent++;
                if (ring < BORDER_RINGS) frame_pixels++;
                else if (ring < GRADIENT_END) faded_pixels++;
            end
            if (!pix.valid || pix.ready) begin
                if (pixels_to_send.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    next_pix = pixels_to_send.pop_front();
                    pix.valid    <= 1'b1;
                    pix.row      <= next_pix.row;
                    pix.col      <= next_pix.col;
                    pix.red_in   <= next_pix.red;
                    pix.green_in <= next_pix.green;
                    pix.blue_in  <= next_pix.blue;
                    pix.alpha_in <= next_pix.alpha;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rgba want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (darkened_due.size() == 0) begin
                    report_mismatch("beat with nothing pending", 1, 0);
                end else begin
                    want = darkened_due.pop_front();
                    if (res.red_out !== want.red)
                        report_mismatch("red", res.red_out, want.red);
                    if (res.green_out !== want.green)
                        report_mismatch("green", res.green_out, want.green);
                    if (res.blue_out !== want.blue)
                        report_mismatch("blue", res.blue_out, want.blue);
                    if (res.alpha_out !== want.alpha)
                        report_mismatch("alpha", res.alpha_out, want.alpha);
                end
                results_checked++;
            end
            res.ready <= !output_held && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Long output stall so the pipeline fills and backs up into the input.
    always begin
        wait (stall_request);
        @(posedge i_clk);
        output_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        output_held <= 1'b0;
        stall_request = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, darkened_due.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        pix.valid        = 1'b0;
        pix.row          = '0;
        pix.col          = '0;
        pix.red_in       = '0;
        pix.green_in     = '0;
        pix.blue_in      = '0;
        pix.alpha_in     = '0;
        res.ready        = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stall_request    = 1'b0;
        output_held      = 1'b0;
        mismatches       = 0;
        pixels_sent      = 0;
        results_checked  = 0;
        frame_pixels     = 0;
        faded_pixels     = 0;
        cycle_count      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // frame corners and edges, fade band edges, ring corners, interior
        add_pixel(0, 0, 255, 255, 255, 255);
        add_pixel(63, 63, 0, 0, 0, 0);
        add_pixel(3, 30, 255, 17, 200, 18);
        add_pixel(30, 60, 9, 9, 9, 0);
        add_pixel(63, 0, 255, 0, 255, 0);
        add_pixel(0, 63, 0, 255, 0, 255);
        add_pixel(4, 30, 255, 255, 255, 0);
        add_pixel(30, 59, 255, 0, 128, 77);
        add_pixel(59, 30, 0, 255, 255, 255);
        add_pixel(30, 4, 1, 2, 3, 4);
        add_pixel(4, 4, 255, 255, 255, 255);
        add_pixel(4, 59, 255, 255, 255, 170);
        add_pixel(59, 59, 200, 100, 50, 85);
        add_pixel(7, 56, 200, 100, 50, 1);
        add_pixel(8, 40, 0, 0, 0, 255);
        add_pixel(11, 30, 255, 255, 255, 128);
        add_pixel(11, 11, 255, 255, 255, 128);
        add_pixel(52, 11, 255, 128, 0, 64);
        add_pixel(12, 40, 255, 255, 255, 128);
        add_pixel(40, 51, 0, 255, 0, 32);
        add_pixel(31, 31, 255, 255, 255, 255);
        add_pixel(32, 31, 255, 254, 253, 0);
        add_pixel(20, 20, 0, 255, 0, 16);
        add_pixel(42, 21, 170, 85, 255, 2);
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
                default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
            endcase
            repeat (phase == 0 ? 320 : 360) pixels_to_send = {pixels_to_send, random_pixel()};
            if (phase == 0 || phase == 3) stall_request = 1'b1;
            wait_for_drain();
        end

        repeat (SETTLE_TICKS) @(negedge i_clk);
        $display("%0d pixels sent, %0d results checked, across four idling phases",
                 pixels_sent, results_checked);
        $display("%0d in the black frame, %0d in the fade band, two long output stalls",
                 frame_pixels, faded_pixels);
        if (mismatches == 0 && darkened_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
